/* hdl/ffba_pkg.sv */
// Shared types, codes and command/status bundles for the first-fit block allocator.
package ffba_pkg;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam int          NEED_W         = 15;
    localparam int          CFG_W          = 17;
    localparam logic [16:0] HEAP_BYTES_RST = 17'h10000;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [16:0] request_bytes;
        logic [15:0] payload_address;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_address;
    } t_out_beat;

    typedef enum logic [1:0] {
        RS_ZERO,
        RS_HDR,
        RS_NEXT
    } t_rd_sel;

    typedef enum logic [2:0] {
        WS_NONE,
        WS_INIT,
        WS_TAKE,
        WS_SPLIT,
        WS_FREE,
        WS_KEEP,
        WS_MERGE
    } t_wr_sel;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        t_rd_sel    rd_sel;
        logic       cur_ld;
        logic       hdr_ld;
        t_wr_sel    wr_sel;
        logic       res_ld;
        logic [1:0] res_code;
        logic       res_addr_en;
        logic       out_ld;
    } t_ctl_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       req_zero;
        logic       ready;
        logic       limit_zero;
        logic       free_skip;
        logic       hdr_zero;
        logic       next_out;
        logic       fits;
        logic       split;
        logic       split_in;
        logic       nx_free;
        logic       out_free;
    } t_ctl_sts;

endpackage

/* hdl/ffba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ffba_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/ffba_ctrl.sv */
// Controller state machine sequencing init, allocate walk and free merge.
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_ctl_sts i_sts,
    output logic     o_in_stall,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DECODE  = 7'b0000010,
        S_WALK    = 7'b0000100,
        S_SPLIT   = 7'b0001000,
        S_FREE    = 7'b0010000,
        S_FREE_NX = 7'b0100000,
        S_FINISH  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = RS_ZERO;
        o_cmd.wr_sel = WS_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.res_ld = 1'b1;
                n_state      = S_FINISH;
                case (i_sts.op)
                    OP_INIT: begin
                        o_cmd.wr_sel   = WS_INIT;
                        o_cmd.res_code = ST_DONE;
                    end
                    OP_ALLOC: begin
                        if (i_sts.req_zero || !i_sts.ready) begin
                            o_cmd.res_code = ST_REJECT;
                        end else if (i_sts.limit_zero) begin
                            o_cmd.res_code = ST_NOFIT;
                        end else begin
                            o_cmd.res_ld = 1'b0;
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RS_ZERO;
                            o_cmd.cur_ld = 1'b1;
                            n_state      = S_WALK;
                        end
                    end
                    OP_FREE: begin
                        if (!i_sts.ready) begin
                            o_cmd.res_code = ST_REJECT;
                        end else if (i_sts.free_skip) begin
                            o_cmd.res_code = ST_DONE;
                        end else begin
                            o_cmd.res_ld = 1'b0;
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RS_HDR;
                            o_cmd.cur_ld = 1'b1;
                            n_state      = S_FREE;
                        end
                    end
                    default: begin
                        o_cmd.res_code = ST_REJECT;
                    end
                endcase
            end
            S_WALK: begin
                o_cmd.hdr_ld = 1'b1;
                if (i_sts.hdr_zero) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_code = ST_NOFIT;
                    n_state        = S_FINISH;
                end else if (i_sts.fits) begin
                    o_cmd.wr_sel = WS_TAKE;
                    if (i_sts.split) begin
                        n_state = S_SPLIT;
                    end else begin
                        o_cmd.res_ld      = 1'b1;
                        o_cmd.res_code    = ST_DONE;
                        o_cmd.res_addr_en = 1'b1;
                        n_state           = S_FINISH;
                    end
                end else if (i_sts.next_out) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_code = ST_NOFIT;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_NEXT;
                    o_cmd.cur_ld = 1'b1;
                end
            end
            S_SPLIT: begin
                if (i_sts.split_in) begin
                    o_cmd.wr_sel = WS_SPLIT;
                end
                o_cmd.res_ld      = 1'b1;
                o_cmd.res_code    = ST_DONE;
                o_cmd.res_addr_en = 1'b1;
                n_state           = S_FINISH;
            end
            S_FREE: begin
                o_cmd.hdr_ld = 1'b1;
                if (!i_sts.next_out && !i_sts.hdr_zero) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_NEXT;
                    n_state      = S_FREE_NX;
                end else begin
                    o_cmd.wr_sel   = WS_FREE;
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_code = ST_DONE;
                    n_state        = S_FINISH;
                end
            end
            S_FREE_NX: begin
                o_cmd.wr_sel   = i_sts.nx_free ? WS_MERGE : WS_KEEP;
                o_cmd.res_ld   = 1'b1;
                o_cmd.res_code = ST_DONE;
                n_state        = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef NO_ASSERTIONS
    a_split_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> ($past(o_cmd.wr_sel) == WS_TAKE))
        else $error("split state entered without a take write");
    a_out_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |-> i_sts.out_free)
        else $error("result loaded into a full output stage");
    a_load_then_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DECODE))
        else $error("accepted beat not decoded");
`endif

endmodule

/* hdl/ffba_dpath.sv */
// Datapath: header store, walk cursor, heap limit, result and output registers.
module ffba_dpath
    import ffba_pkg::*;
#(
    parameter int HEAP_BYTES = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_beat         i_in_beat,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_out_stall,
    input  t_ctl_cmd         i_cmd,
    output t_ctl_sts         o_sts,
    output logic             o_out_valid,
    output t_out_beat        o_out_beat
);

    localparam int GRANULES = HEAP_BYTES / 8;
    localparam int GW       = $clog2(GRANULES + 1);
    localparam int AW       = $clog2(GRANULES);
    localparam int CW       = GW + 1;

    logic [1:0]        r_op;
    logic              r_req_zero;
    logic [NEED_W-1:0] r_need;
    logic [15:0]       r_addr;
    logic [CW-1:0]     r_cur;
    logic [GW-1:0]     r_bs;
    logic [GW-1:0]     r_limit;
    logic              r_ready;
    logic [CFG_W-1:0]  r_heap_bytes;
    logic [1:0]        r_res_status;
    logic [15:0]       r_res_addr;
    t_out_beat         r_out;
    logic              r_out_valid;

    logic [GW:0]   rd_data;
    logic [GW-1:0] rd_size;
    logic          rd_alloc;
    logic [31:0]   h32;
    logic [31:0]   nxt32;
    logic [31:0]   spl32;
    logic [31:0]   merge32;
    logic [31:0]   sel32;
    logic [31:0]   res32;
    logic [13:0]   g14;
    logic [GW-1:0] g_sat;
    logic [GW-1:0] merge_sat;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [GW:0]   wr_data;
    logic [GW-1:0] n_bs;

    assign rd_size  = rd_data[GW:1];
    assign rd_alloc = rd_data[0];

    assign h32     = 32'(r_addr[15:3]) - 32'd1;
    assign nxt32   = 32'(r_cur) + 32'(rd_size);
    assign spl32   = 32'(r_cur) + 32'(r_need);
    assign merge32 = 32'(r_bs) + 32'(rd_size);
    assign res32   = 32'(r_cur) + 32'd1;
    assign g14     = r_heap_bytes[16:3];
    assign g_sat     = (32'(g14) > GRANULES) ? GW'(GRANULES) : GW'(g14);
    assign merge_sat = (merge32 > GRANULES) ? GW'(GRANULES) : merge32[GW-1:0];

    always_comb begin
        case (i_cmd.rd_sel)
            RS_ZERO: sel32 = 32'd0;
            RS_HDR:  sel32 = h32;
            RS_NEXT: sel32 = nxt32;
            default: sel32 = 32'd0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_cur[AW-1:0];
        wr_data = '0;
        n_bs    = r_bs;
        case (i_cmd.wr_sel)
            WS_INIT: begin
                wr_addr = '0;
                wr_data = {g_sat, 1'b0};
            end
            WS_TAKE: begin
                n_bs    = o_sts.split ? GW'(r_need) : rd_size;
                wr_data = {n_bs, 1'b1};
            end
            WS_SPLIT: begin
                wr_addr = spl32[AW-1:0];
                wr_data = {r_bs - GW'(r_need), 1'b0};
            end
            WS_FREE:  wr_data = {rd_size, 1'b0};
            WS_KEEP:  wr_data = {r_bs, 1'b0};
            WS_MERGE: wr_data = {merge_sat, 1'b0};
            default:  wr_en = 1'b0;
        endcase
    end

    ffba_ram #(
        .WIDTH (GW + 1),
        .DEPTH (GRANULES)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (sel32[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready      <= 1'b0;
            r_limit      <= '0;
            r_heap_bytes <= HEAP_BYTES_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_heap_bytes <= i_cfg_data;
            end
            if (i_cmd.wr_sel == WS_INIT) begin
                r_ready <= 1'b1;
                r_limit <= g_sat;
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_in_beat.opcode;
            r_req_zero <= (i_in_beat.request_bytes == '0);
            r_need     <= NEED_W'((18'(i_in_beat.request_bytes) + 18'd15) >> 3);
            r_addr     <= i_in_beat.payload_address;
        end
        if (i_cmd.cur_ld) begin
            r_cur <= CW'(sel32);
        end
        if (i_cmd.hdr_ld) begin
            r_bs <= rd_size;
        end
        if (i_cmd.res_ld) begin
            r_res_status <= i_cmd.res_code;
            r_res_addr   <= i_cmd.res_addr_en ? {res32[12:0], 3'b000} : 16'd0;
        end
        if (i_cmd.out_ld) begin
            r_out.status         <= r_res_status;
            r_out.result_address <= r_res_addr;
        end
    end

    assign o_sts.op         = r_op;
    assign o_sts.req_zero   = r_req_zero;
    assign o_sts.ready      = r_ready;
    assign o_sts.limit_zero = (r_limit == '0);
    assign o_sts.free_skip  = (r_addr == 16'd0) || (r_addr[2:0] != 3'd0)
                              || (h32 >= 32'(r_limit));
    assign o_sts.hdr_zero   = (rd_size == '0);
    assign o_sts.next_out   = (nxt32 >= 32'(r_limit));
    assign o_sts.fits       = !rd_alloc && (32'(rd_size) >= 32'(r_need));
    assign o_sts.split      = (32'(rd_size) >= (32'(r_need) + 32'd2));
    assign o_sts.split_in   = (spl32 < GRANULES);
    assign o_sts.nx_free    = !rd_alloc;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

`ifndef NO_ASSERTIONS
    a_init_sets_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_sel == WS_INIT) |=> r_ready)
        else $error("init did not mark the heap ready");
    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res_ld && (i_cmd.res_code != ST_DONE)) |-> !i_cmd.res_addr_en)
        else $error("address reported on a failed operation");
    a_walk_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_sel == WS_TAKE) |-> (32'(r_cur) < 32'(r_limit)))
        else $error("take beyond the heap limit");
`endif

endmodule

/* hdl/first_fit_block_allocator.sv */
// Top level of the first-fit block allocator: controller plus datapath.
//
//   channel  | valid       | stall        | payload
//   ---------+-------------+--------------+-------------------------------
//   request  | i_in_valid  | o_in_stall   | i_in_beat  (t_in_beat)
//   result   | o_out_valid | i_out_stall  | o_out_beat (t_out_beat)
//   config   | i_cfg_we    | -            | i_cfg_data (heap_bytes)
//
// Per beat, with the result side free: init, rejects and skipped frees go from decode to finish;
// free reads its header, and also the next header when that lies within the heap.
// Allocate reads headers in turn until one fits or the walk ends, plus a split step when split.
// The result is registered, then moved to the output stage once it is free; a stalled result holds,
// the next beat may be accepted and then waits in the finish state until it drains.
// Reset clears control and heap_ready; the header store holds garbage until init.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int HEAP_BYTES = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_beat         i_in_beat,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_beat        o_out_beat,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    ffba_dpath #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_beat   (i_in_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

endmodule
